// ===== hdl/rmc_pkg.sv =====
`timescale 1ns / 1ps

package rmc_pkg;

	// Frame size limits and field widths
	localparam int MAX_FRAME_BYTES_DEF = 256;
	localparam int LEN_W = 9;

	// Modbus CRC-16: reflected polynomial, all-ones preset
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_SHORT = 2'd1,
		ST_CRC   = 2'd2,
		ST_LONG  = 2'd3
	} status_t;

	typedef struct packed {
		status_t          status;
		logic [LEN_W-1:0] frame_length;
		logic [15:0]      reply_value;
		logic [7:0]       reply_byte_count;
	} result_t;

	// One byte through the CRC, LSB first
	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ===== hdl/modbus_rtu_response_checker_unit.sv =====
`timescale 1ns / 1ps
// Modbus RTU reply checker: CRC-16 check and field capture, one byte word per item.
// A closing word passes the input register; its result is loaded into the result register
// once that register is free. Throughput: one word per cycle, but a closing word waits
// for room in the result register. The byte-wide CRC update sits between the registers.
// Reset (arst_n low, asynchronous): both registers empty, CRC preset to all ones,
// frame counters and captured fields cleared.

module modbus_rtu_response_checker_unit import rmc_pkg::*; #(
	parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       rx_byte,
	input  logic             frame_end,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [1:0]       status,
	output logic [LEN_W-1:0] frame_length,
	output logic [15:0]      reply_value,
	output logic [7:0]       reply_byte_count
);

	// Input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// Result register
	logic    out_valid_q;
	result_t out_q;

	logic    out_free;
	logic    adv_s1;
	result_t res;

	// The result register can take a new word when empty or being drained.
	assign out_free = !out_valid_q || out_ready;

	// Mid-frame words never produce a result, so they always advance;
	// the closing word waits for room in the result register.
	assign adv_s1   = valid_s1 && (!last_s1 || out_free);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload needs no reset; load only on accept
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
			last_s1 <= frame_end;
		end
	end

	// Frame state, CRC and result decode
	rmc_frame_tracker #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_tracker (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (adv_s1),
		.rx_byte  (byte_s1),
		.frame_end(last_s1),
		.res      (res)
	);

	// Hold the result until the consumer takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			out_q <= res;
		end
	end

	assign out_valid        = out_valid_q;
	assign status           = 2'(out_q.status);
	assign frame_length     = out_q.frame_length;
	assign reply_value      = out_q.reply_value;
	assign reply_byte_count = out_q.reply_byte_count;

endmodule

// ===== hdl/rmc_frame_tracker.sv =====
`timescale 1ns / 1ps

module rmc_frame_tracker import rmc_pkg::*; #(
	parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  rx_byte,
	input  logic        frame_end,
	output result_t     res
);

	localparam logic [LEN_W-1:0] MaxCnt = LEN_W'(MAX_FRAME_BYTES);

	logic [15:0]      crc_q, crc_nxt;
	logic [15:0]      held_q, held_nxt;
	logic [LEN_W-1:0] cnt_q, cnt_nxt;
	logic [7:0]       count_q, count_nxt;
	logic [7:0]       hi_q, hi_nxt;
	logic [7:0]       lo_q, lo_nxt;
	logic             ovf_q, ovf_nxt;
	logic [15:0]      got;
	status_t          st;

	// Fold this word into the frame state
	always_comb begin
		crc_nxt   = crc_q;
		held_nxt  = held_q;
		cnt_nxt   = cnt_q;
		count_nxt = count_q;
		hi_nxt    = hi_q;
		lo_nxt    = lo_q;
		ovf_nxt   = ovf_q;
		if (cnt_q < MaxCnt) begin
			if (cnt_q >= LEN_W'(2)) begin
				crc_nxt = crc_feed(crc_q, held_q[15:8]);
			end
			held_nxt = {held_q[7:0], rx_byte};
			if (cnt_q == LEN_W'(2)) begin
				count_nxt = rx_byte;
			end
			if (cnt_q == LEN_W'(3)) begin
				hi_nxt = rx_byte;
			end
			if (cnt_q == LEN_W'(4)) begin
				lo_nxt = rx_byte;
			end
			cnt_nxt = cnt_q + LEN_W'(1);
		end else begin
			ovf_nxt = 1'b1;
		end
	end

	// Trailer arrives low byte first
	assign got = {held_nxt[7:0], held_nxt[15:8]};

	always_comb begin
		priority if (cnt_nxt < LEN_W'(3)) begin
			st = ST_SHORT;
		end else if (ovf_nxt) begin
			st = ST_LONG;
		end else if (got == crc_nxt) begin
			st = ST_OK;
		end else begin
			st = ST_CRC;
		end
	end

	always_comb begin
		res.status           = st;
		res.frame_length     = cnt_nxt;
		res.reply_byte_count = count_nxt;
		if (st != ST_OK) begin
			res.reply_value = 16'h0000;
		end else if (count_nxt == 8'd1) begin
			res.reply_value = {8'h00, hi_nxt};
		end else begin
			res.reply_value = {hi_nxt, lo_nxt};
		end
	end

	// Clear everything at frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q   <= CRC_INIT;
			held_q  <= '0;
			cnt_q   <= '0;
			count_q <= '0;
			hi_q    <= '0;
			lo_q    <= '0;
			ovf_q   <= 1'b0;
		end else if (step) begin
			if (frame_end) begin
				crc_q   <= CRC_INIT;
				held_q  <= '0;
				cnt_q   <= '0;
				count_q <= '0;
				hi_q    <= '0;
				lo_q    <= '0;
				ovf_q   <= 1'b0;
			end else begin
				crc_q   <= crc_nxt;
				held_q  <= held_nxt;
				cnt_q   <= cnt_nxt;
				count_q <= count_nxt;
				hi_q    <= hi_nxt;
				lo_q    <= lo_nxt;
				ovf_q   <= ovf_nxt;
			end
		end
	end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import rmc_pkg::*;

	localparam int FRAME_CAP = MAX_FRAME_BYTES_DEF;
	localparam int RANDOM_WORDS = 1150;
	localparam int CHOKE_AFTER = 150;
	localparam int CHOKE_CYCLES = 500;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT = 400000;

	// Where a directed byte comes from: typed in, or the low/high byte of the
	// CRC over the frame so far.
	typedef enum logic [1:0] {
		FILL_RAW,
		FILL_CRC_LO,
		FILL_CRC_HI
	} fill_t;

	typedef struct packed {
		logic [7:0] data;
		logic       is_end;
		fill_t      fill;
		logic       typed;
		result_t    exp;
	} dir_row_t;

	localparam result_t NO_EXP = '{ST_OK, 9'd0, 16'h0000, 8'h00};

	// Directed frames. Only the short frames carry a typed expectation; the rest
	// go through the reply predictor.
	localparam dir_row_t DIR_TAB [26] = '{
		// one byte: too short
		'{8'h00, 1'b1, FILL_RAW, 1'b1, '{ST_SHORT, 9'd1, 16'h0000, 8'h00}},
		// two bytes: still too short, nothing captured
		'{8'hFF, 1'b0, FILL_RAW, 1'b0, NO_EXP},
		'{8'hFF, 1'b1, FILL_RAW, 1'b1, '{ST_SHORT, 9'd2, 16'h0000, 8'h00}},
		// three bytes with good CRC: the high CRC byte lands in the count field
		'{8'h5A, 1'b0, FILL_RAW, 1'b0, NO_EXP},
		'{8'h00, 1'b0, FILL_CRC_LO, 1'b0, NO_EXP},
		'{8'h00, 1'b1, FILL_CRC_HI, 1'b0, NO_EXP},
		// count of one: value is the single byte at position 3
		'{8'h11, 1'b0, FILL_RAW, 1'b0, NO_EXP},
		'{8'h03, 1'b0, FILL_RAW, 1'b0, NO_EXP},
		'{8'h01, 1'b0, FILL_RAW, 1'b0, NO_EXP},
		'{8'hA5, 1'b0, FILL_RAW, 1'b0, NO_EXP},
		'{8'h00, 1'b0, FILL_CRC_LO, 1'b0, NO_EXP},
		'{8'h00, 1'b1, FILL_CRC_HI, 1'b0, NO_EXP},
		// count of two, all-ones value
		'{8'hFF, 1'b0, FILL_RAW, 1'b0, NO_EXP},
		'{8'h03, 1'b0, FILL_RAW, 1'b0, NO_EXP},
		'{8'h02, 1'b0, FILL_RAW, 1'b0, NO_EXP},
		'{8'hFF, 1'b0, FILL_RAW, 1'b0, NO_EXP},
		'{8'hFF, 1'b0, FILL_RAW, 1'b0, NO_EXP},
		'{8'h00, 1'b0, FILL_CRC_LO, 1'b0, NO_EXP},
		'{8'h00, 1'b1, FILL_CRC_HI, 1'b0, NO_EXP},
		// CRC mismatch: value must read zero
		'{8'h01, 1'b0, FILL_RAW, 1'b0, NO_EXP},
		'{8'h03, 1'b0, FILL_RAW, 1'b0, NO_EXP},
		'{8'h02, 1'b0, FILL_RAW, 1'b0, NO_EXP},
		'{8'h80, 1'b0, FILL_RAW, 1'b0, NO_EXP},
		'{8'h00, 1'b0, FILL_RAW, 1'b0, NO_EXP},
		'{8'h00, 1'b0, FILL_RAW, 1'b0, NO_EXP},
		'{8'h00, 1'b1, FILL_RAW, 1'b0, NO_EXP}
	};

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	logic [7:0]       rx_byte;
	logic             frame_end;
	logic             out_valid;
	logic             out_ready;
	logic [1:0]       status;
	logic [LEN_W-1:0] frame_length;
	logic [15:0]      reply_value;
	logic [7:0]       reply_byte_count;

	modbus_rtu_response_checker_unit dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.rx_byte          (rx_byte),
		.frame_end        (frame_end),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.status           (status),
		.frame_length     (frame_length),
		.reply_value      (reply_value),
		.reply_byte_count (reply_byte_count)
	);

	// Reply predictor state: mirrors one frame in flight
	logic [15:0] frame_crc;
	logic [15:0] tail_pair;
	int          rx_count;
	logic [7:0]  count_byte;
	logic [7:0]  val_hi;
	logic [7:0]  val_lo;
	logic        overrun;

	result_t     awaited_replies[$];
	result_t     want;
	logic [7:0]  frame_buf[$];
	int          words_in;
	int          fault_count;
	int          cycle_count;
	logic        no_gaps;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Modbus CRC-16, one byte, LSB first
	function automatic logic [15:0] crc16_modbus(input logic [15:0] acc, input logic [7:0] d);
		logic [15:0] c;
		c = acc ^ {8'h00, d};
		repeat (8) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
		return c;
	endfunction

	function automatic void clear_reply_state();
		frame_crc = 16'hFFFF;
		tail_pair = 16'h0000;
		rx_count = 0;
		count_byte = 8'h00;
		val_hi = 8'h00;
		val_lo = 8'h00;
		overrun = 1'b0;
	endfunction

	// Advance the predictor by one accepted word; return 1 with the reply on a frame end
	function automatic bit judge_reply_byte(input logic [7:0] d, input logic is_end,
			output result_t r);
		status_t     st;
		logic [15:0] got;
		r = NO_EXP;
		if (rx_count < FRAME_CAP) begin
			// the older held byte is now known not to be a CRC byte
			if (rx_count >= 2)
				frame_crc = crc16_modbus(frame_crc, tail_pair[15:8]);
			tail_pair = {tail_pair[7:0], d};
			case (rx_count)
				2: count_byte = d;
				3: val_hi = d;
				4: val_lo = d;
				default: ;
			endcase
			rx_count++;
		end else begin
			overrun = 1'b1;
		end
		if (!is_end)
			return 0;
		got = {tail_pair[7:0], tail_pair[15:8]};
		if (rx_count < 3)
			st = ST_SHORT;
		else if (overrun)
			st = ST_LONG;
		else if (got == frame_crc)
			st = ST_OK;
		else
			st = ST_CRC;
		r.status = st;
		r.frame_length = LEN_W'(rx_count);
		r.reply_byte_count = count_byte;
		if (st == ST_OK)
			r.reply_value = (count_byte == 8'h01) ? {8'h00, val_hi} : {val_hi, val_lo};
		else
			r.reply_value = 16'h0000;
		clear_reply_state();
		return 1;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Offer one word, hold it until accepted, then log the expected reply
	task automatic send_word(input logic [7:0] d, input logic is_end, input logic use_typed,
			input result_t typed_exp);
		int      gap;
		result_t r;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= d;
		frame_end <= is_end;
		do @(posedge clk); while (!in_ready);
		words_in++;
		if (judge_reply_byte(d, is_end, r))
			awaited_replies.push_back(use_typed ? typed_exp : r);
	endtask

	task automatic send_frame();
		for (int i = 0; i < frame_buf.size(); i++)
			send_word(frame_buf[i], i == frame_buf.size() - 1, 1'b0, NO_EXP);
	endtask

	// Reply-shaped frame with a correct CRC trailer
	task automatic build_good(input int data_len);
		logic [15:0] acc;
		logic [7:0]  d;
		int          r;
		frame_buf.delete();
		acc = 16'hFFFF;
		for (int i = 0; i < data_len; i++) begin
			r = $urandom_range(0, 99);
			case (i)
				1: d = (r < 45) ? 8'h03 : (r < 90) ? 8'h04 : 8'($urandom);
				2: d = (r < 50) ? 8'h01 : (r < 80) ? 8'h02 : 8'($urandom);
				default: d = 8'($urandom);
			endcase
			frame_buf.push_back(d);
			acc = crc16_modbus(acc, d);
		end
		frame_buf.push_back(acc[7:0]);
		frame_buf.push_back(acc[15:8]);
	endtask

	task automatic build_noise(input int len);
		frame_buf.delete();
		repeat (len) frame_buf.push_back(8'($urandom));
	endtask

	// Stimulus: reset, directed table, then random frames
	initial begin : stimulus
		dir_row_t    row;
		logic [15:0] walk_crc;
		logic [7:0]  d;
		int          frame_no;
		int          kind;
		int          pos;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		rx_byte <= 8'h00;
		frame_end <= 1'b0;
		no_gaps = 1'b0;
		words_in = 0;
		clear_reply_state();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		walk_crc = 16'hFFFF;
		foreach (DIR_TAB[i]) begin
			row = DIR_TAB[i];
			case (row.fill)
				FILL_CRC_LO: d = walk_crc[7:0];
				FILL_CRC_HI: d = walk_crc[15:8];
				default: begin
					d = row.data;
					walk_crc = crc16_modbus(walk_crc, d);
				end
			endcase
			send_word(d, row.is_end, row.typed, row.exp);
			if (row.is_end)
				walk_crc = 16'hFFFF;
		end

		// mostly well-formed replies, some corrupted, short and noise frames;
		// one frame at the size limit and one past it
		frame_no = 0;
		while (words_in < RANDOM_WORDS) begin
			no_gaps = ($urandom_range(0, 3) == 0);
			if (frame_no == 15) begin
				build_good(FRAME_CAP - 2);
			end else if (frame_no == 40) begin
				build_noise($urandom_range(FRAME_CAP + 1, FRAME_CAP + 3));
			end else begin
				kind = $urandom_range(0, 99);
				if (kind < 80) begin
					build_good($urandom_range(1, 12));
					if (kind >= 65) begin
						pos = $urandom_range(0, frame_buf.size() - 1);
						frame_buf[pos] = frame_buf[pos] ^ (8'h01 << $urandom_range(0, 7));
					end
				end else if (kind < 88) begin
					build_noise($urandom_range(1, 2));
				end else begin
					build_noise($urandom_range(3, 12));
				end
			end
			send_frame();
			frame_no++;
		end
		in_valid <= 1'b0;
		frame_end <= 1'b0;

		while (awaited_replies.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fault_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Receiver: random stalls, plus one long hold-off to back the block up
	initial begin : drain
		bit choked;
		int r;
		choked = 1'b0;
		out_ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (!choked && words_in >= CHOKE_AFTER) begin
				choked = 1'b1;
				out_ready <= 1'b0;
				repeat (CHOKE_CYCLES) @(posedge clk);
			end
			r = $urandom_range(0, 99);
			if (r < 50) begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end else if (r < 55) begin
				out_ready <= 1'b1;
				repeat ($urandom_range(30, 100)) @(posedge clk);
			end else if (r < 88) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end else if (r < 97) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(4, 20)) @(posedge clk);
			end else begin
				out_ready <= 1'b0;
				repeat ($urandom_range(30, 80)) @(posedge clk);
			end
		end
	end

	// Reply checker: compare each accepted reply with the oldest expectation
	initial fault_count = 0;

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (awaited_replies.size() == 0) begin
				fault_count++;
				if (fault_count <= 10)
					$display("unexpected reply: status %0d len %0d value %h count %h",
						status, frame_length, reply_value, reply_byte_count);
			end else begin
				want = awaited_replies.pop_front();
				if (status !== want.status || frame_length !== want.frame_length ||
						reply_value !== want.reply_value ||
						reply_byte_count !== want.reply_byte_count) begin
					fault_count++;
					if (fault_count <= 10)
						$display("reply mismatch: exp status %0d len %0d value %h count %h,",
							want.status, want.frame_length, want.reply_value,
							want.reply_byte_count,
							" got status %0d len %0d value %h count %h",
							status, frame_length, reply_value, reply_byte_count);
				end
			end
		end
	end

	// Watchdog: end a hung run
	initial cycle_count = 0;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

endmodule
